FILE: sv/sorted_key_value_table_defines.svh
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH
// assertion helpers
`define SKV_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("skv check failed");
`define SKV_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("skv check failed");
`endif

FILE: sv/skvt_pkg.sv
package skvt_pkg;
  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    CMD_GET = 3'd0, CMD_PUT = 3'd1, CMD_REMOVE_KEY = 3'd2,
    CMD_REMOVE_AT = 3'd3, CMD_INDEX_KEY = 3'd4, CMD_INDEX_VALUE = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2, ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_WAIT, S_SRCH_CHK, S_VSCAN, S_VSCAN_WAIT,
    S_DECIDE, S_READ_VAL, S_READ_WAIT, S_SHIFT, S_SHIFT_WAIT, S_WRITE, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_INIT, OP_PROBE, OP_PROBE_CHK, OP_VPROBE, OP_WRITE, OP_SHIFT_RD
  } op_t;

  typedef struct packed {
    op_t op;
    logic insert;
    logic shift_wr;
    logic shift_step;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic hit;
    logic vhit;
    logic vdone;
    logic shift_done;
  } dp_stat_t;
endpackage

FILE: sv/skvt_if.sv
interface skvt_in_if;
  logic valid;
  logic ready;
  logic [2:0] command;
  logic signed [31:0] key;
  logic [31:0] value;
  logic [5:0] position;
  modport source (output valid, command, key, value, position, input ready);
  modport sink (input valid, command, key, value, position, output ready);
endinterface

interface skvt_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [5:0] found_index;
  logic [31:0] found_value;
  logic [6:0] entry_count;
  modport source (output valid, status, found_index, found_value, entry_count, input ready);
  modport sink (input valid, status, found_index, found_value, entry_count, output ready);
endinterface

FILE: sv/sorted_key_value_table.sv
// channel | dir | payload
// in      | in  | command, key, value, position
// out     | out | status, found_index, found_value, entry_count
// Get and index-of-key lookups run a binary search over the key RAM.
// Insert and remove then move entries one at a time through a shift loop.
// Index of value scans the value RAM entry by entry, starting from index zero.
// Reset is synchronous; it empties the table. A stalled result holds; a new transaction
// is taken once the previous result register can be refilled.
`include "sorted_key_value_table_defines.svh"
module sorted_key_value_table (
  input logic clk,
  input logic rst,
  skvt_in_if.sink in_ch,
  skvt_out_if.source out_ch
);
  skvt_pkg::dp_cmd_t cmd;
  skvt_pkg::dp_stat_t stat;
  logic in_take, res_load, pos_ok, full;
  logic [2:0] command;

  skvt_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .in_take, .res_load, .cmd, .stat, .command, .pos_ok, .full
  );

  skvt_datapath u_dp (
    .clk, .rst, .cmd, .stat, .in_take,
    .in_command(in_ch.command), .in_key(in_ch.key),
    .in_value(in_ch.value), .in_position(in_ch.position),
    .res_load,
    .status(out_ch.status), .found_index(out_ch.found_index),
    .found_value(out_ch.found_value), .entry_count(out_ch.entry_count),
    .command, .pos_ok, .full
  );

  `SKV_ASSERT_IMPL(a_no_take_busy, clk, rst, in_take, !out_ch.valid || out_ch.ready)
  `SKV_ASSERT_NEXT(a_load_valid, clk, rst, res_load, out_ch.valid)
  `SKV_ASSERT_IMPL(a_count_cap, clk, rst, out_ch.valid, out_ch.entry_count <= 7'd64)
endmodule

FILE: sv/skvt_datapath.sv
module skvt_datapath (
  input  logic clk,
  input  logic rst,
  input  skvt_pkg::dp_cmd_t cmd,
  output skvt_pkg::dp_stat_t stat,
  input  logic in_take,
  input  logic [2:0] in_command,
  input  logic signed [31:0] in_key,
  input  logic [31:0] in_value,
  input  logic [5:0] in_position,
  input  logic res_load,
  output logic [1:0] status,
  output logic [5:0] found_index,
  output logic [31:0] found_value,
  output logic [6:0] entry_count,
  output logic [2:0] command,
  output logic pos_ok,
  output logic full
);
  localparam int IW = skvt_pkg::IdxW;
  localparam int CW = skvt_pkg::CntW;

  logic [31:0] key_mem [skvt_pkg::Capacity];
  logic [31:0] val_mem [skvt_pkg::Capacity];
  logic [31:0] rd_key, rd_val;
  logic [IW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [31:0] wr_key, wr_val;

  logic [31:0] key_r, val_r;
  logic [IW-1:0] pos_r;
  logic [CW-1:0] count, lo, hi, idx;
  logic [CW:0] mid_sum;
  logic [CW-1:0] mid;
  logic hit, vhit;
  logic [31:0] hold_val;
  logic [CW-1:0] hit_idx;
  logic full_put, pos_ok_r;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[CW:1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

  always_comb begin
    rd_addr = idx[IW-1:0];
    case (cmd.op)
      skvt_pkg::OP_PROBE: rd_addr = mid[IW-1:0];
      skvt_pkg::OP_SHIFT_RD: rd_addr = cmd.insert ? IW'(idx - CW'(1)) : IW'(idx + CW'(1));
      default: rd_addr = idx[IW-1:0];
    endcase
    wr_en = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_key = key_r;
    wr_val = val_r;
    if (cmd.op == skvt_pkg::OP_WRITE) begin
      wr_en = 1'b1;
      if (!cmd.insert) wr_key = rd_key;
    end else if (cmd.shift_wr) begin
      wr_en = 1'b1;
      wr_key = rd_key;
      wr_val = rd_val;
      wr_addr = cmd.insert ? IW'(idx + CW'(1)) : IW'(idx - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.op == skvt_pkg::OP_WRITE && cmd.insert) count <= count + CW'(1);
      if (cmd.op == skvt_pkg::OP_SHIFT_RD && !cmd.insert && cmd.shift_step &&
          idx + CW'(1) == count) count <= count - CW'(1);
    end
    if (in_take) begin
      command <= in_command;
      key_r <= in_key;
      val_r <= in_value;
      pos_r <= in_position;
    end
    case (cmd.op)
      skvt_pkg::OP_INIT: begin
        lo <= '0;
        hi <= count;
        idx <= '0;
        hit <= 1'b0;
        vhit <= 1'b0;
      end
      skvt_pkg::OP_PROBE_CHK: begin
        if ((rd_key ^ 32'h8000_0000) < (key_r ^ 32'h8000_0000)) lo <= mid + CW'(1);
        else hi <= mid;
      end
      skvt_pkg::OP_VPROBE: begin
        if (rd_val == val_r) vhit <= 1'b1;
        else idx <= idx + CW'(1);
      end
      skvt_pkg::OP_SHIFT_RD: begin
        if (cmd.shift_step) idx <= cmd.insert ? idx - CW'(1) : idx + CW'(1);
      end
      default: ;
    endcase
    if (cmd.op == skvt_pkg::OP_PROBE && lo == hi) begin
      idx <= lo;
    end
    if (cmd.op == skvt_pkg::OP_NONE && cmd.shift_step) begin
      hit <= (idx < count) && (rd_key == key_r);
      hold_val <= rd_val;
      if (command == skvt_pkg::CMD_REMOVE_AT) idx <= CW'(pos_r);
      else if (command == skvt_pkg::CMD_PUT && !((idx < count) && (rd_key == key_r)))
        idx <= count;
    end
    if (cmd.op == skvt_pkg::OP_NONE && cmd.insert) begin
      hold_val <= rd_val;
    end
    if (res_load) begin
      entry_count <= 7'(count);
      case (command)
        skvt_pkg::CMD_GET, skvt_pkg::CMD_INDEX_KEY, skvt_pkg::CMD_REMOVE_KEY: begin
          if (hit) begin
            status <= skvt_pkg::ST_OK;
            found_index <= 6'(hit_idx);
            found_value <= hold_val;
          end else begin
            status <= skvt_pkg::ST_NOT_FOUND;
            found_index <= '0;
            found_value <= '0;
          end
        end
        skvt_pkg::CMD_PUT: begin
          if (hit || !full_put) begin
            status <= skvt_pkg::ST_OK;
            found_index <= 6'(hit_idx);
            found_value <= val_r;
          end else begin
            status <= skvt_pkg::ST_FULL;
            found_index <= '0;
            found_value <= '0;
          end
        end
        skvt_pkg::CMD_REMOVE_AT: begin
          if (pos_ok_r) begin
            status <= skvt_pkg::ST_OK;
            found_index <= 6'(pos_r);
            found_value <= hold_val;
          end else begin
            status <= skvt_pkg::ST_RANGE;
            found_index <= '0;
            found_value <= '0;
          end
        end
        skvt_pkg::CMD_INDEX_VALUE: begin
          if (vhit) begin
            status <= skvt_pkg::ST_OK;
            found_index <= 6'(idx);
            found_value <= val_r;
          end else begin
            status <= skvt_pkg::ST_NOT_FOUND;
            found_index <= '0;
            found_value <= '0;
          end
        end
        default: begin
          status <= skvt_pkg::ST_NOT_FOUND;
          found_index <= '0;
          found_value <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == skvt_pkg::OP_NONE && cmd.shift_step) begin
      hit_idx <= idx;
      full_put <= (count == CW'(skvt_pkg::Capacity));
      pos_ok_r <= CW'(pos_r) < count;
    end
  end

  assign pos_ok = CW'(pos_r) < count;
  assign full = count == CW'(skvt_pkg::Capacity);

  assign stat.search_done = (lo == hi);
  assign stat.hit = hit;
  assign stat.vhit = vhit;
  assign stat.vdone = vhit || (idx >= count);
  assign stat.shift_done = cmd.insert ? (idx == hit_idx) : (idx + CW'(1) == count);
endmodule

FILE: sv/skvt_ctrl.sv
module skvt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic in_take,
  output logic res_load,
  output skvt_pkg::dp_cmd_t cmd,
  input  skvt_pkg::dp_stat_t stat,
  input  logic [2:0] command,
  input  logic pos_ok,
  input  logic full
);
  skvt_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skvt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    res_load = 1'b0;
    in_ready = 1'b0;
    in_take = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      skvt_pkg::S_IDLE: begin
        in_ready = !out_valid || out_ready;
        in_take = in_valid && in_ready;
        if (in_take) state_next = skvt_pkg::S_SRCH;
      end
      skvt_pkg::S_SRCH: begin
        cmd.op = skvt_pkg::OP_INIT;
        state_next = (command == skvt_pkg::CMD_INDEX_VALUE) ?
                     skvt_pkg::S_VSCAN : skvt_pkg::S_SRCH_WAIT;
      end
      skvt_pkg::S_SRCH_WAIT: begin
        cmd.op = skvt_pkg::OP_PROBE;
        state_next = stat.search_done ? skvt_pkg::S_DECIDE : skvt_pkg::S_SRCH_CHK;
      end
      skvt_pkg::S_SRCH_CHK: begin
        cmd.op = skvt_pkg::OP_PROBE_CHK;
        state_next = skvt_pkg::S_SRCH_WAIT;
      end
      skvt_pkg::S_VSCAN: begin
        state_next = stat.vdone ? skvt_pkg::S_OUT : skvt_pkg::S_VSCAN_WAIT;
      end
      skvt_pkg::S_VSCAN_WAIT: begin
        cmd.op = skvt_pkg::OP_VPROBE;
        state_next = skvt_pkg::S_VSCAN;
      end
      skvt_pkg::S_DECIDE: begin
        cmd.shift_step = 1'b1;
        state_next = skvt_pkg::S_READ_VAL;
      end
      skvt_pkg::S_READ_VAL: begin
        state_next = skvt_pkg::S_OUT;
        case (command)
          skvt_pkg::CMD_PUT: begin
            if (stat.hit) state_next = skvt_pkg::S_WRITE;
            else if (!full) state_next = skvt_pkg::S_SHIFT;
          end
          skvt_pkg::CMD_REMOVE_KEY: if (stat.hit) state_next = skvt_pkg::S_READ_WAIT;
          skvt_pkg::CMD_REMOVE_AT: if (pos_ok) state_next = skvt_pkg::S_READ_WAIT;
          default: ;
        endcase
      end
      skvt_pkg::S_READ_WAIT: begin
        cmd.insert = 1'b1;
        state_next = skvt_pkg::S_SHIFT;
      end
      skvt_pkg::S_SHIFT: begin
        cmd.insert = (command == skvt_pkg::CMD_PUT);
        cmd.op = skvt_pkg::OP_SHIFT_RD;
        if (stat.shift_done && cmd.insert) state_next = skvt_pkg::S_WRITE;
        else begin
          cmd.shift_step = 1'b1;
          state_next = stat.shift_done ? skvt_pkg::S_OUT : skvt_pkg::S_SHIFT_WAIT;
        end
      end
      skvt_pkg::S_SHIFT_WAIT: begin
        cmd.insert = (command == skvt_pkg::CMD_PUT);
        cmd.shift_wr = 1'b1;
        state_next = skvt_pkg::S_SHIFT;
      end
      skvt_pkg::S_WRITE: begin
        cmd.op = skvt_pkg::OP_WRITE;
        cmd.insert = !stat.hit;
        state_next = skvt_pkg::S_OUT;
      end
      skvt_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          res_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = skvt_pkg::S_IDLE;
        end
      end
      default: state_next = skvt_pkg::S_IDLE;
    endcase
  end
endmodule

FILE: sim/skvt_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces are provided by the RTL (skvt_in_if, skvt_out_if).
// This file holds the shared stimulus row type used by the testbench.
package skvt_tb_pkg;
  typedef struct {
    logic [2:0]         command;
    logic signed [31:0] key;
    logic [31:0]        value;
    logic [5:0]         position;
    bit                 has_expect;
    skvt_pkg::status_t  status;
    logic [5:0]         found_index;
    logic [31:0]        found_value;
    logic [6:0]         entry_count;
  } stim_row_t;
endpackage

FILE: sim/tb_sorted_key_value_table.sv
`timescale 1ns / 1ps
module tb_sorted_key_value_table;
  localparam int WatchdogLimit = 20000;
  localparam int RandomItems = 320;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    skvt_pkg::status_t status;
    logic [5:0]        found_index;
    logic [31:0]       found_value;
    logic [6:0]        entry_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skvt_in_if  in_ch ();
  skvt_out_if out_ch ();

  sorted_key_value_table u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #4 clk = ~clk;

  logic signed [31:0] model_keys [skvt_pkg::Capacity];
  logic [31:0]        model_vals [skvt_pkg::Capacity];
  int                 model_count;
  answer_t            pending_answers [$];
  int                 errors = 0;
  int                 sent = 0;
  int                 received = 0;
  int                 idle_cycles = 0;
  bit                 stim_done = 0;
  bit                 calm = 0;
  bit                 hold_off = 0;
  int                 op_hits [8];

  function automatic answer_t table_apply(logic [2:0] cmd, logic signed [31:0] k,
                                          logic [31:0] v, logic [5:0] pos);
    answer_t a;
    int lo, hi, mid, lb, j;
    bit hit;
    a.status = skvt_pkg::ST_NOT_FOUND;
    a.found_index = '0;
    a.found_value = '0;
    lo = 0;
    hi = model_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (model_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    lb = lo;
    hit = (lb < model_count) && (model_keys[lb] == k);
    case (cmd)
      skvt_pkg::CMD_GET, skvt_pkg::CMD_INDEX_KEY: begin
        if (hit) begin
          a.status = skvt_pkg::ST_OK; a.found_index = 6'(lb); a.found_value = model_vals[lb];
        end
      end
      skvt_pkg::CMD_PUT: begin
        if (hit) begin
          model_vals[lb] = v;
          a.status = skvt_pkg::ST_OK; a.found_index = 6'(lb); a.found_value = v;
        end else if (model_count >= skvt_pkg::Capacity) begin
          a.status = skvt_pkg::ST_FULL;
        end else begin
          for (j = model_count; j > lb; j--) begin
            model_keys[j] = model_keys[j-1];
            model_vals[j] = model_vals[j-1];
          end
          model_keys[lb] = k;
          model_vals[lb] = v;
          model_count++;
          a.status = skvt_pkg::ST_OK; a.found_index = 6'(lb); a.found_value = v;
        end
      end
      skvt_pkg::CMD_REMOVE_KEY, skvt_pkg::CMD_REMOVE_AT: begin
        if (cmd == skvt_pkg::CMD_REMOVE_AT) begin
          hit = int'(pos) < model_count;
          lb = int'(pos);
          if (!hit) a.status = skvt_pkg::ST_RANGE;
        end
        if (hit) begin
          a.status = skvt_pkg::ST_OK; a.found_index = 6'(lb); a.found_value = model_vals[lb];
          for (j = lb; j + 1 < model_count; j++) begin
            model_keys[j] = model_keys[j+1];
            model_vals[j] = model_vals[j+1];
          end
          model_count--;
        end
      end
      skvt_pkg::CMD_INDEX_VALUE: begin
        for (j = 0; j < model_count; j++) begin
          if (model_vals[j] == v) begin
            a.status = skvt_pkg::ST_OK; a.found_index = 6'(j); a.found_value = v;
            break;
          end
        end
      end
      default: ;
    endcase
    a.entry_count = 7'(model_count);
    return a;
  endfunction

  task automatic send_command(skvt_tb_pkg::stim_row_t r);
    answer_t a;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= r.command;
    in_ch.key      <= r.key;
    in_ch.value    <= r.value;
    in_ch.position <= r.position;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    a = table_apply(r.command, r.key, r.value, r.position);
    op_hits[r.command]++;
    if (r.has_expect) begin
      if (a.status != r.status || a.found_index != r.found_index ||
          a.found_value != r.found_value || a.entry_count != r.entry_count) begin
        $error("table row, command %0d: expected %0d/%0d/%h/%0d, predictor %0d/%0d/%h/%0d",
               r.command, r.status, r.found_index, r.found_value, r.entry_count,
               a.status, a.found_index, a.found_value, a.entry_count);
        errors++;
      end
      a.status = r.status;
      a.found_index = r.found_index;
      a.found_value = r.found_value;
      a.entry_count = r.entry_count;
    end
    pending_answers.push_back(a);
    sent++;
    @(negedge clk);
  endtask

  function automatic skvt_tb_pkg::stim_row_t row(logic [2:0] c, logic signed [31:0] k,
                                                 logic [31:0] v, logic [5:0] p);
    skvt_tb_pkg::stim_row_t r;
    r.command = c; r.key = k; r.value = v; r.position = p;
    r.has_expect = 0;
    r.status = skvt_pkg::ST_OK; r.found_index = '0; r.found_value = '0; r.entry_count = '0;
    return r;
  endfunction

  function automatic skvt_tb_pkg::stim_row_t row_x(logic [2:0] c, logic signed [31:0] k,
                                                   logic [31:0] v, logic [5:0] p,
                                                   skvt_pkg::status_t s, logic [5:0] i,
                                                   logic [31:0] fv, logic [6:0] n);
    skvt_tb_pkg::stim_row_t r;
    r = row(c, k, v, p);
    r.has_expect = 1;
    r.status = s; r.found_index = i; r.found_value = fv; r.entry_count = n;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_key(int span);
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom();
      default: return $signed($urandom_range(0, span)) - span / 2;
    endcase
  endfunction

  initial begin
    skvt_tb_pkg::stim_row_t directed [$];
    skvt_tb_pkg::stim_row_t r;
    int i, span;
    in_ch.valid = 1'b0;
    in_ch.command = skvt_pkg::CMD_GET;
    in_ch.key = '0;
    in_ch.value = '0;
    in_ch.position = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed.push_back(row_x(skvt_pkg::CMD_GET, 0, 0, 0, skvt_pkg::ST_NOT_FOUND, 0, 0, 0));
    directed.push_back(row_x(skvt_pkg::CMD_REMOVE_AT, 0, 0, 0, skvt_pkg::ST_RANGE, 0, 0, 0));
    directed.push_back(row_x(skvt_pkg::CMD_INDEX_VALUE, 0, 0, 0,
                             skvt_pkg::ST_NOT_FOUND, 0, 0, 0));
    directed.push_back(row_x(skvt_pkg::CMD_PUT, 32'sh7fff_ffff, 32'hffff_ffff, 0,
                             skvt_pkg::ST_OK, 0, 32'hffff_ffff, 1));
    directed.push_back(row_x(skvt_pkg::CMD_PUT, 32'sh8000_0000, 32'h0000_0001, 0,
                             skvt_pkg::ST_OK, 0, 32'h0000_0001, 2));
    directed.push_back(row(skvt_pkg::CMD_PUT, -1, 32'h5555_5555, 0));
    directed.push_back(row(skvt_pkg::CMD_PUT, 0, 32'haaaa_aaaa, 0));
    directed.push_back(row(skvt_pkg::CMD_PUT, 0, 32'h1234_5678, 0));
    directed.push_back(row(skvt_pkg::CMD_GET, 32'sh7fff_ffff, 0, 0));
    directed.push_back(row(skvt_pkg::CMD_INDEX_KEY, -1, 0, 0));
    directed.push_back(row(skvt_pkg::CMD_INDEX_KEY, 7, 0, 0));
    directed.push_back(row(skvt_pkg::CMD_INDEX_VALUE, 0, 32'hffff_ffff, 0));
    directed.push_back(row(skvt_pkg::CMD_INDEX_VALUE, 0, 32'h0bad_0bad, 0));
    directed.push_back(row_x(CMD_SPARE6, 0, 0, 0, skvt_pkg::ST_NOT_FOUND, 0, 0, 4));
    directed.push_back(row_x(CMD_SPARE7, 0, 0, 0, skvt_pkg::ST_NOT_FOUND, 0, 0, 4));
    directed.push_back(row(skvt_pkg::CMD_REMOVE_KEY, 5, 0, 0));
    directed.push_back(row(skvt_pkg::CMD_REMOVE_KEY, -1, 0, 0));
    directed.push_back(row_x(skvt_pkg::CMD_REMOVE_AT, 0, 0, 63, skvt_pkg::ST_RANGE, 0, 0, 3));
    directed.push_back(row(skvt_pkg::CMD_REMOVE_AT, 0, 0, 2));
    directed.push_back(row(skvt_pkg::CMD_REMOVE_AT, 0, 0, 0));
    foreach (directed[n]) send_command(directed[n]);

    // fill to capacity under receiver hold-off, then exercise the full table
    hold_off = 1;
    i = 0;
    while (model_count < skvt_pkg::Capacity) begin
      send_command(row(skvt_pkg::CMD_PUT, $signed($urandom_range(0, 4000)) - 2000,
                       $urandom(), 0));
      i++;
    end
    send_command(row(skvt_pkg::CMD_PUT, 32'sh7fff_fffe, 32'h1, 0));
    send_command(row(skvt_pkg::CMD_PUT, model_keys[skvt_pkg::Capacity-1], 32'hdead_beef, 0));
    send_command(row(skvt_pkg::CMD_INDEX_VALUE, 0, model_vals[skvt_pkg::Capacity-1], 0));
    send_command(row(skvt_pkg::CMD_REMOVE_AT, 0, 0, 6'd63));
    send_command(row(skvt_pkg::CMD_GET, model_keys[0], 0, 0));

    for (i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - 60) calm = 1;
      span = (i % 100 < 50) ? 64 : 4000;
      r = row($urandom_range(0, 7), pick_key(span), $urandom(), $urandom());
      case ($urandom_range(0, 9))
        0, 1, 2: r.command = skvt_pkg::CMD_PUT;
        3: if (model_count > 0) r.key = model_keys[$urandom_range(0, model_count - 1)];
        4: begin
          if (model_count > 0) r.value = model_vals[$urandom_range(0, model_count - 1)];
          r.command = skvt_pkg::CMD_INDEX_VALUE;
        end
        5: begin
          r.command = skvt_pkg::CMD_REMOVE_AT;
          r.position = $urandom_range(0, model_count > 0 ? model_count : 0);
        end
        6: r.value = $urandom_range(0, 3);
        default: ;
      endcase
      if (r.command == skvt_pkg::CMD_PUT && $urandom_range(0, 2) == 0 && model_count > 0)
        r.key = model_keys[$urandom_range(0, model_count - 1)];
      send_command(r);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!hold_off) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
    end
    out_ch.ready <= 1'b0;
    repeat (600) @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      received <= received + 1;
      if (pending_answers.size() == 0) begin
        $error("unexpected result: status %0d", out_ch.status);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          errors++;
        end
        if (out_ch.found_index !== e.found_index) begin
          $error("found_index: expected %0d, got %0d", e.found_index, out_ch.found_index);
          errors++;
        end
        if (out_ch.found_value !== e.found_value) begin
          $error("found_value: expected %h, got %h", e.found_value, out_ch.found_value);
          errors++;
        end
        if (out_ch.entry_count !== e.entry_count) begin
          $error("entry_count: expected %0d, got %0d", e.entry_count, out_ch.entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired: %0d sent, %0d received", sent, received);
        $display("tb_sorted_key_value_table NOT OK");
        $finish;
      end
      if (stim_done && pending_answers.size() == 0) begin
        repeat (400) @(posedge clk);
        $display("commands sent %0d, results checked %0d, final entry count %0d",
                 sent, received, model_count);
        $display("per command: get %0d put %0d rmkey %0d rmat %0d idxkey %0d idxval %0d",
                 op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5]);
        if (errors == 0 && pending_answers.size() == 0)
          $display("tb_sorted_key_value_table OK");
        else
          $display("tb_sorted_key_value_table NOT OK");
        $finish;
      end
    end
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/skvt_pkg.sv
sv/skvt_if.sv
sv/skvt_datapath.sv
sv/skvt_ctrl.sv
sv/sorted_key_value_table.sv
sim/skvt_tb_if.sv
sim/tb_sorted_key_value_table.sv
